// File: sv/brs_pkg.sv
//----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the ramp smoother
// command codes, queue entry, register indexes, control structs
//----------------------------------------------------------------------------
package brs_pkg;

	localparam int MAX_BLOCK   = 64;
	localparam int CNT_W       = $clog2(MAX_BLOCK);
	localparam int LEN_W       = 7;
	localparam int COEF_W      = 17;
	localparam int SMP_W       = 24;
	localparam int ACC_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

	// input command codes
	localparam logic [1:0] CMD_NEW    = 2'd0;
	localparam logic [1:0] CMD_CONT   = 2'd1;
	localparam logic [1:0] CMD_SINGLE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_COEF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_VALUE   = 2'd3;

	typedef enum logic [1:0] {
		OP_NEW,
		OP_CONT,
		OP_SINGLE
	} brs_op_t;

	typedef struct packed {
		brs_op_t                 op;
		logic signed [SMP_W-1:0] target;
	} brs_entry_t;

	typedef struct packed {
		logic       valid;
		brs_entry_t entry;
	} brs_push_t;

	typedef struct packed {
		logic       valid;
		brs_entry_t entry;
	} brs_head_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} brs_div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
	} brs_div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL_X,
		S_MUL_Y,
		S_FILT,
		S_SCALE,
		S_EMIT
	} brs_state_t;

	typedef enum logic [1:0] {
		MODE_IDLE_RES,
		MODE_SINGLE,
		MODE_BLOCK
	} brs_mode_t;

endpackage

// File: sv/brs_cmd_if.sv
//----------------------------------------------------------------------------
// brs_cmd_if: command channel
// valid/ready channel carrying one command item
//----------------------------------------------------------------------------
interface brs_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         command;
	logic signed [brs_pkg::SMP_W-1:0]   target;

	modport source (output valid, output command, output target, input ready);
	modport sink   (input valid, input command, input target, output ready);
endinterface

// File: sv/brs_res_if.sv
//----------------------------------------------------------------------------
// brs_res_if: result channel
// valid/ready channel carrying one smoothed sample item
//----------------------------------------------------------------------------
interface brs_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [brs_pkg::SMP_W-1:0]   sample_out;
	logic                               active;
	logic                               last;

	modport source (output valid, output sample_out, output active, output last, input ready);
	modport sink   (input valid, input sample_out, input active, input last, output ready);
endinterface

// File: sv/brs_front.sv
//----------------------------------------------------------------------------
// brs_front: command intake
// decodes the command code, drops unused codes, pushes into the queue
//----------------------------------------------------------------------------
module brs_front (
	brs_cmd_if.sink              cmd_ch,
	input  logic                 full,
	output brs_pkg::brs_push_t   push
);

	logic            known;
	brs_pkg::brs_op_t op;

	always_comb begin
		known = 1'b1;
		op    = brs_pkg::OP_NEW;
		case (cmd_ch.command)
			brs_pkg::CMD_NEW:    op = brs_pkg::OP_NEW;
			brs_pkg::CMD_CONT:   op = brs_pkg::OP_CONT;
			brs_pkg::CMD_SINGLE: op = brs_pkg::OP_SINGLE;
			default:             known = 1'b0;
		endcase
	end

	assign cmd_ch.ready        = !full;
	assign push.valid          = cmd_ch.valid && !full && known;
	assign push.entry.op       = op;
	assign push.entry.target   = cmd_ch.target;

endmodule

// File: sv/brs_queue.sv
//----------------------------------------------------------------------------
// brs_queue: command queue
// short fifo between intake and execution
//----------------------------------------------------------------------------
module brs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brs_pkg::brs_push_t   push,
	input  logic                 pop,
	output logic                 full,
	output brs_pkg::brs_head_t   head
);

	brs_pkg::brs_entry_t             mem_q [brs_pkg::QUEUE_DEPTH];
	logic [brs_pkg::QPTR_W-1:0]      wptr_q;
	logic [brs_pkg::QPTR_W-1:0]      rptr_q;
	logic [brs_pkg::QPTR_W:0]        count_q;

	assign full       = (count_q == (brs_pkg::QPTR_W+1)'(brs_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/brs_div.sv
//----------------------------------------------------------------------------
// brs_div: step divider
// restoring unsigned division, one quotient bit per cycle
//----------------------------------------------------------------------------
module brs_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  brs_pkg::brs_div_req_t  req,
	output brs_pkg::brs_div_rsp_t  rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [brs_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [brs_pkg::LEN_W-1:0]         rem_q;
	logic [brs_pkg::ACC_W-1:0]         quo_q;
	logic [brs_pkg::LEN_W-1:0]         div_q;

	logic [brs_pkg::LEN_W:0]           rem_sh;
	logic                              ge;
	logic [brs_pkg::LEN_W:0]           rem_n;

	assign rem_sh = {rem_q[brs_pkg::LEN_W-1:0], quo_q[brs_pkg::ACC_W-1]};
	assign ge     = (rem_sh >= {1'b0, div_q});
	assign rem_n  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[brs_pkg::ACC_W-2:0], ge};
			// remainder stays below the divisor, so it fits the length width
			rem_q <= rem_n[brs_pkg::LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == brs_pkg::DIV_CNT_W'(brs_pkg::DIV_STEPS-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: sv/brs_back.sv
//----------------------------------------------------------------------------
// brs_back: execution engine
// ramp, one-pole lowpass on a shared multiplier, result register
//----------------------------------------------------------------------------
module brs_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [brs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  brs_pkg::brs_head_t                     head,
	output logic                                   pop,
	output brs_pkg::brs_div_req_t                  div_req,
	input  brs_pkg::brs_div_rsp_t                  div_rsp,
	brs_res_if.source                              res_ch
);

	localparam logic signed [34:0] SAT32_HI = 35'sd2147483647;
	localparam logic signed [34:0] SAT32_LO = -35'sd2147483648;
	localparam logic signed [33:0] RMP_HI   = 34'sd2147483647;
	localparam logic signed [33:0] RMP_LO   = -34'sd2147483648;
	localparam logic signed [24:0] SAT24_HI = 25'sd8388607;
	localparam logic signed [24:0] SAT24_LO = -25'sd8388608;

	// configuration
	logic [brs_pkg::LEN_W-1:0]         blen_q;
	logic [brs_pkg::COEF_W-1:0]        feed_q;
	logic [brs_pkg::COEF_W-1:0]        fb_q;

	// smoother state
	logic signed [brs_pkg::ACC_W-1:0]  ramp_q;
	logic signed [brs_pkg::ACC_W-1:0]  filter_q;
	logic signed [brs_pkg::SMP_W-1:0]  current_q;
	logic signed [brs_pkg::SMP_W-1:0]  target_q;
	logic                              smoothing_q;

	// working registers
	brs_pkg::brs_state_t               state_q;
	brs_pkg::brs_state_t               state_n;
	brs_pkg::brs_mode_t                mode_q;
	logic [brs_pkg::CNT_W-1:0]         cnt_q;
	logic signed [brs_pkg::ACC_W-1:0]  x_q;
	logic signed [32:0]                step_q;
	logic                              dneg_q;
	logic signed [49:0]                prod_x_q;
	logic signed [49:0]                prod_y_q;
	logic signed [brs_pkg::SMP_W-1:0]  res_sample_q;
	logic                              res_active_q;
	logic signed [brs_pkg::SMP_W-1:0]  first_q;

	// result register
	logic                              out_valid_q;
	logic signed [brs_pkg::SMP_W-1:0]  out_sample_q;
	logic                              out_active_q;
	logic                              out_last_q;

	// datapath
	logic signed [brs_pkg::SMP_W-1:0]  tgt;
	logic signed [brs_pkg::ACC_W-1:0]  tgt_x;
	logic signed [brs_pkg::SMP_W-1:0]  tgt_eff;
	logic                              idle_hit;
	logic signed [32:0]                dv;
	logic signed [32:0]                dv_neg;
	logic signed [32:0]                quo_s;
	logic signed [31:0]                mul_a;
	logic signed [17:0]                mul_b;
	logic signed [49:0]                mul_p;
	logic signed [50:0]                flt_sum;
	logic signed [34:0]                flt_y;
	logic signed [brs_pkg::ACC_W-1:0]  flt_sat;
	logic signed [32:0]                sc_sum;
	logic signed [24:0]                sc_y;
	logic signed [brs_pkg::SMP_W-1:0]  sc_sat;
	logic signed [33:0]                rp_sum;
	logic signed [brs_pkg::ACC_W-1:0]  rp_sat;
	logic                              is_final;
	logic                              out_load;
	logic                              ends_here;
	logic signed [brs_pkg::SMP_W-1:0]  first_s;
	logic [brs_pkg::LEN_W-1:0]         cfg_len;
	logic [brs_pkg::COEF_W-1:0]        cfg_coef;

	assign tgt      = head.entry.target;
	assign tgt_x    = {tgt, 8'h00};
	assign tgt_eff  = (head.entry.op == brs_pkg::OP_NEW) ? tgt : target_q;
	assign idle_hit = !smoothing_q && (current_q == tgt_eff);

	// step numerator, magnitude goes to the divider
	assign dv       = 33'(tgt_x) - 33'(ramp_q);
	assign dv_neg   = -dv;
	assign quo_s    = {1'b0, div_rsp.quotient};

	// shared multiplier
	always_comb begin
		if (state_q == brs_pkg::S_MUL_Y) begin
			mul_a = filter_q;
			mul_b = {1'b0, fb_q};
		end else begin
			mul_a = (mode_q == brs_pkg::MODE_SINGLE) ? x_q : ramp_q;
			mul_b = {1'b0, feed_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	// round to q1.31 and saturate
	assign flt_sum = 51'(prod_x_q) + 51'(prod_y_q) + 51'sd32768;
	assign flt_y   = flt_sum[50:16];
	always_comb begin
		if (flt_y > SAT32_HI) begin
			flt_sat = 32'sh7FFFFFFF;
		end else if (flt_y < SAT32_LO) begin
			flt_sat = 32'sh80000000;
		end else begin
			flt_sat = flt_y[31:0];
		end
	end

	// q1.31 to q1.23 with rounding
	assign sc_sum = 33'(filter_q) + 33'sd128;
	assign sc_y   = sc_sum[32:8];
	always_comb begin
		if (sc_y > SAT24_HI) begin
			sc_sat = 24'sh7FFFFF;
		end else if (sc_y < SAT24_LO) begin
			sc_sat = 24'sh800000;
		end else begin
			sc_sat = sc_y[23:0];
		end
	end

	// saturating ramp advance
	assign rp_sum = 34'(ramp_q) + 34'(step_q);
	always_comb begin
		if (rp_sum > RMP_HI) begin
			rp_sat = 32'sh7FFFFFFF;
		end else if (rp_sum < RMP_LO) begin
			rp_sat = 32'sh80000000;
		end else begin
			rp_sat = rp_sum[31:0];
		end
	end

	assign is_final  = (mode_q != brs_pkg::MODE_BLOCK) ||
	                   ({1'b0, cnt_q} == (blen_q - 1'b1));
	assign first_s   = (cnt_q == '0) ? res_sample_q : first_q;
	assign ends_here = (first_s == res_sample_q);

	// config value clamping
	always_comb begin
		if (cfg_data[brs_pkg::LEN_W-1:0] == '0) begin
			cfg_len = brs_pkg::LEN_W'(1);
		end else if (cfg_data[brs_pkg::LEN_W-1:0] > brs_pkg::LEN_W'(brs_pkg::MAX_BLOCK)) begin
			cfg_len = brs_pkg::LEN_W'(brs_pkg::MAX_BLOCK);
		end else begin
			cfg_len = cfg_data[brs_pkg::LEN_W-1:0];
		end
		if (cfg_data[brs_pkg::COEF_W-1:0] > brs_pkg::COEF_ONE) begin
			cfg_coef = brs_pkg::COEF_ONE;
		end else begin
			cfg_coef = cfg_data[brs_pkg::COEF_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			brs_pkg::S_IDLE: begin
				if (head.valid) begin
					if (head.entry.op == brs_pkg::OP_SINGLE) begin
						state_n = brs_pkg::S_MUL_X;
					end else if (idle_hit) begin
						state_n = brs_pkg::S_EMIT;
					end else if (head.entry.op == brs_pkg::OP_NEW) begin
						state_n = brs_pkg::S_DIV;
					end else begin
						state_n = brs_pkg::S_MUL_X;
					end
				end
			end
			brs_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_n = brs_pkg::S_MUL_X;
				end
			end
			brs_pkg::S_MUL_X: state_n = brs_pkg::S_MUL_Y;
			brs_pkg::S_MUL_Y: state_n = brs_pkg::S_FILT;
			brs_pkg::S_FILT:  state_n = brs_pkg::S_SCALE;
			brs_pkg::S_SCALE: state_n = brs_pkg::S_EMIT;
			brs_pkg::S_EMIT: begin
				if (out_load) begin
					state_n = is_final ? brs_pkg::S_IDLE : brs_pkg::S_MUL_X;
				end
			end
			default: state_n = brs_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop              = (state_q == brs_pkg::S_IDLE) && head.valid;
		out_load         = (state_q == brs_pkg::S_EMIT) && (!out_valid_q || res_ch.ready);
		div_req.start    = pop && (head.entry.op == brs_pkg::OP_NEW) && !idle_hit;
		div_req.dividend = dv[32] ? dv_neg[31:0] : dv[31:0];
		div_req.divisor  = blen_q;
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.sample_out = out_sample_q;
	assign res_ch.active     = out_active_q;
	assign res_ch.last       = out_last_q;

	// working payload
	always_ff @(posedge clk) begin
		case (state_q)
			brs_pkg::S_IDLE: begin
				x_q          <= tgt_x;
				dneg_q       <= dv[32];
				step_q       <= '0;
				cnt_q        <= '0;
				res_sample_q <= current_q;
				res_active_q <= !(head.entry.op != brs_pkg::OP_SINGLE && idle_hit);
				if (head.entry.op == brs_pkg::OP_SINGLE) begin
					mode_q <= brs_pkg::MODE_SINGLE;
				end else if (idle_hit) begin
					mode_q <= brs_pkg::MODE_IDLE_RES;
				end else begin
					mode_q <= brs_pkg::MODE_BLOCK;
				end
			end
			brs_pkg::S_DIV: begin
				if (div_rsp.done) begin
					step_q <= dneg_q ? -quo_s : quo_s;
				end
			end
			brs_pkg::S_MUL_X: prod_x_q <= mul_p;
			brs_pkg::S_MUL_Y: prod_y_q <= mul_p;
			brs_pkg::S_SCALE: res_sample_q <= sc_sat;
			brs_pkg::S_EMIT: begin
				if (out_load) begin
					first_q <= first_s;
					cnt_q   <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_sample_q <= res_sample_q;
			out_active_q <= res_active_q;
			out_last_q   <= is_final;
		end
	end

	// control and smoother state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			blen_q      <= brs_pkg::LEN_W'(32);
			feed_q      <= brs_pkg::COEF_ONE;
			fb_q        <= '0;
			ramp_q      <= '0;
			filter_q    <= '0;
			current_q   <= '0;
			target_q    <= '0;
			smoothing_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				brs_pkg::S_IDLE: begin
					if (head.valid && head.entry.op == brs_pkg::OP_NEW) begin
						target_q <= tgt;
					end
					if (head.valid && head.entry.op != brs_pkg::OP_SINGLE && !idle_hit) begin
						smoothing_q <= 1'b1;
					end
				end
				brs_pkg::S_FILT: begin
					filter_q <= flt_sat;
					if (mode_q == brs_pkg::MODE_BLOCK) begin
						ramp_q <= rp_sat;
					end
				end
				brs_pkg::S_EMIT: begin
					if (out_load && mode_q == brs_pkg::MODE_BLOCK && is_final) begin
						if (ends_here) begin
							smoothing_q <= 1'b0;
							current_q   <= target_q;
						end else begin
							current_q   <= res_sample_q;
						end
					end
				end
				default: ;
			endcase

			// register writes must arrive only while idle; the block itself does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					brs_pkg::REG_BLOCK_LEN:     blen_q <= cfg_len;
					brs_pkg::REG_FEED_COEF:     feed_q <= cfg_coef;
					brs_pkg::REG_FEEDBACK_COEF: fb_q   <= cfg_coef;
					brs_pkg::REG_START_VALUE: begin
						ramp_q    <= {cfg_data[brs_pkg::SMP_W-1:0], 8'h00};
						filter_q  <= {cfg_data[brs_pkg::SMP_W-1:0], 8'h00};
						current_q <= cfg_data[brs_pkg::SMP_W-1:0];
						target_q  <= cfg_data[brs_pkg::SMP_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sv/block_ramp_smoother_top.sv
//----------------------------------------------------------------------------
// block_ramp_smoother_top: linear ramp plus one-pole parameter smoother
// command intake, queue, step divider and filter engine
//----------------------------------------------------------------------------
// flow: an idle item goes from the queue through the emit state to the result register;
//   a single item passes both multiplier states, filter and scale before emit; a block
//   item repeats those states for each sample, after the divider on command 0; emit
//   holds while the result register is full and not taken, and items pop only in idle
// reset: registers return to block_len 32, feed 1.0, feedback 0, start value 0;
//   ramp, filter, current and target clear, smoothing off, queue empty
module block_ramp_smoother_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [brs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]      cfg_data,
	brs_cmd_if.sink                             cmd_ch,
	brs_res_if.source                           res_ch
);

	// front to queue: decoded item, command 3 is dropped here
	brs_pkg::brs_push_t     push;
	logic                   full;

	// queue to back: head item, popped once the engine is free
	brs_pkg::brs_head_t     head;
	logic                   pop;

	// back to divider: step numerator magnitude over block length
	brs_pkg::brs_div_req_t  div_req;
	brs_pkg::brs_div_rsp_t  div_rsp;

	// intake keeps taking items while a block is still being emitted, until the queue is full
	brs_front u_front (
		.cmd_ch (cmd_ch),
		.full   (full),
		.push   (push)
	);

	brs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	// one quotient bit per cycle, only command 0 needs a step
	brs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ramp and lowpass, results through a single output register
	brs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_ch    (res_ch)
	);

endmodule

// File: bench/block_ramp_smoother_top_tb.sv
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// block_ramp_smoother_top_tb: self-checking bench for the ramp smoother
// drives command items with random gaps and checks every smoothed sample
// against a bit-exact predictor of the ramp and one-pole lowpass
//----------------------------------------------------------------------------
module block_ramp_smoother_top_tb;

	// command 3 has no meaning, the block drops it
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam logic signed [brs_pkg::SMP_W-1:0] SMP_TOP = 24'sh7FFFFF;
	localparam logic signed [brs_pkg::SMP_W-1:0] SMP_BOT = 24'sh800000;
	localparam longint ACC_TOP   = 64'sd2147483647;
	localparam longint ACC_BOT   = -64'sd2147483648;
	localparam longint OUT_TOP   = 64'sd8388607;
	localparam longint OUT_BOT   = -64'sd8388608;
	localparam longint GAIN_ONE  = 64'sd65536;

	// longest block is 64 samples, plus the divider on command 0
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 600;

	typedef struct {
		logic [1:0]                       command;
		logic signed [brs_pkg::SMP_W-1:0] target;
	} cmd_item_t;

	typedef struct {
		logic signed [brs_pkg::SMP_W-1:0] sample;
		logic                             active;
		logic                             last;
	} smp_item_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [brs_pkg::CFG_DATA_W-1:0] cfg_data;

	brs_cmd_if cmd_ch();
	brs_res_if res_ch();

	block_ramp_smoother_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_ch    (cmd_ch),
		.res_ch    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// commands waiting for the driver, samples waiting for the dut
	cmd_item_t cmd_backlog[$];
	smp_item_t sample_forecast[$];

	int   cmds_queued  = 0;
	int   cmds_taken   = 0;
	int   mismatch_cnt = 0;
	int   hold_asked   = 0;
	logic idle_on      = 1'b1;
	logic cmd_fire     = 1'b0;

	// predictor copy of registers and smoother state
	logic [brs_pkg::LEN_W-1:0]        m_len;
	logic [brs_pkg::COEF_W-1:0]       m_feed;
	logic [brs_pkg::COEF_W-1:0]       m_fb;
	logic signed [brs_pkg::SMP_W-1:0] m_start;
	logic signed [brs_pkg::ACC_W-1:0] m_ramp;
	logic signed [brs_pkg::ACC_W-1:0] m_filt;
	logic signed [brs_pkg::SMP_W-1:0] m_cur;
	logic signed [brs_pkg::SMP_W-1:0] m_tgt;
	logic                             m_smoothing;

	function automatic longint sat_range(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// coefficients above 1.0 clip to 1.0
	function automatic longint coef_gain(logic [brs_pkg::COEF_W-1:0] c);
		return (c > brs_pkg::COEF_ONE) ? GAIN_ONE : longint'(c);
	endfunction

	// one lowpass step on a q1.31 input, returns the q1.23 output
	function automatic logic signed [brs_pkg::SMP_W-1:0] filter_sample(longint x);
		longint acc;
		longint y;
		longint o;
		acc = x * coef_gain(m_feed) + longint'(m_filt) * coef_gain(m_fb);
		y = (acc + 64'sd32768) >>> 16;
		m_filt = brs_pkg::ACC_W'(sat_range(y, ACC_BOT, ACC_TOP));
		o = (longint'(m_filt) + 64'sd128) >>> 8;
		return brs_pkg::SMP_W'(sat_range(o, OUT_BOT, OUT_TOP));
	endfunction

	// expected samples for one accepted command item
	task automatic smooth_command(logic [1:0] c, logic signed [brs_pkg::SMP_W-1:0] t);
		int n;
		longint step;
		logic signed [brs_pkg::SMP_W-1:0] first;
		logic signed [brs_pkg::SMP_W-1:0] s;
		if (c == CMD_IGNORED)
			return;
		if (c == brs_pkg::CMD_SINGLE) begin
			sample_forecast.push_back('{filter_sample(longint'(t) * 256), 1'b1, 1'b1});
			return;
		end
		if (c == brs_pkg::CMD_NEW)
			m_tgt = t;
		// settled and already on target: one inactive item
		if (!m_smoothing && m_cur == m_tgt) begin
			sample_forecast.push_back('{m_cur, 1'b0, 1'b1});
			return;
		end
		m_smoothing = 1'b1;
		n = int'(m_len);
		if (n < 1)
			n = 1;
		if (n > brs_pkg::MAX_BLOCK)
			n = brs_pkg::MAX_BLOCK;
		step = 0;
		if (c == brs_pkg::CMD_NEW)
			step = (longint'(m_tgt) * 256 - longint'(m_ramp)) / n;
		first = '0;
		s = '0;
		for (int k = 0; k < n; k++) begin
			s = filter_sample(longint'(m_ramp));
			if (k == 0)
				first = s;
			m_ramp = brs_pkg::ACC_W'(sat_range(longint'(m_ramp) + step, ACC_BOT, ACC_TOP));
			sample_forecast.push_back('{s, 1'b1, (k == n - 1)});
		end
		m_cur = s;
		// flat block ends smoothing, current snaps to target
		if (first == s) begin
			m_smoothing = 1'b0;
			m_cur = m_tgt;
		end
	endtask

	task automatic flag_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatch_cnt++;
	endtask

	task automatic queue_cmd(logic [1:0] c, logic signed [brs_pkg::SMP_W-1:0] t);
		cmd_backlog.push_back('{c, t});
		cmds_queued++;
	endtask

	// register write, mirrored into the predictor while the block is idle
	task automatic write_reg(logic [brs_pkg::CFG_IDX_W-1:0] idx,
		logic [brs_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			brs_pkg::REG_BLOCK_LEN:     m_len  = val[brs_pkg::LEN_W-1:0];
			brs_pkg::REG_FEED_COEF:     m_feed = val[brs_pkg::COEF_W-1:0];
			brs_pkg::REG_FEEDBACK_COEF: m_fb   = val[brs_pkg::COEF_W-1:0];
			brs_pkg::REG_START_VALUE: begin
				// start value loads ramp, filter, current and target
				m_start = val;
				m_ramp  = brs_pkg::ACC_W'(longint'(m_start) * 256);
				m_filt  = m_ramp;
				m_cur   = m_start;
				m_tgt   = m_start;
			end
			default: ;
		endcase
	endtask

	// extremes and zero show up often, the rest is uniform
	function automatic logic signed [brs_pkg::SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return SMP_TOP;
			1:       return SMP_BOT;
			2:       return '0;
			default: return brs_pkg::SMP_W'($urandom);
		endcase
	endfunction

	task automatic pick_settings();
		logic [brs_pkg::CFG_DATA_W-1:0] len_v;
		logic [brs_pkg::CFG_DATA_W-1:0] a0;
		logic [brs_pkg::CFG_DATA_W-1:0] b1;
		// short blocks mostly, zero and maximum or oversize now and then
		case ($urandom_range(0, 5))
			0:       len_v = '0;
			1:       len_v = brs_pkg::CFG_DATA_W'($urandom_range(64, 127));
			default: len_v = brs_pkg::CFG_DATA_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 3))
			0: begin
				// unity dc gain lowpass
				a0 = brs_pkg::CFG_DATA_W'($urandom_range(0, 65536));
				b1 = brs_pkg::CFG_DATA_W'(65536) - a0;
			end
			1: begin
				// anything the field holds, includes clipping and blow-up
				a0 = brs_pkg::CFG_DATA_W'($urandom_range(0, 131071));
				b1 = brs_pkg::CFG_DATA_W'($urandom_range(0, 131071));
			end
			2: begin
				a0 = '0;
				b1 = brs_pkg::CFG_DATA_W'($urandom_range(0, 131071));
			end
			default: begin
				a0 = brs_pkg::CFG_DATA_W'(brs_pkg::COEF_ONE);
				b1 = '0;
			end
		endcase
		write_reg(brs_pkg::REG_BLOCK_LEN, len_v);
		write_reg(brs_pkg::REG_FEED_COEF, a0);
		write_reg(brs_pkg::REG_FEEDBACK_COEF, b1);
		write_reg(brs_pkg::REG_START_VALUE, brs_pkg::CFG_DATA_W'(pick_sample()));
	endtask

	// mostly new target then a few continues, plus single samples and noise
	task automatic queue_random_phase(int count);
		int made;
		int burst;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					queue_cmd(brs_pkg::CMD_NEW, pick_sample());
					made++;
					burst = $urandom_range(1, 4);
					repeat (burst) begin
						// target field is don't-care on continue, still random
						queue_cmd(brs_pkg::CMD_CONT, brs_pkg::SMP_W'($urandom));
						made++;
					end
				end
				7: begin
					queue_cmd(brs_pkg::CMD_SINGLE, pick_sample());
					made++;
				end
				8: queue_cmd(CMD_IGNORED, brs_pkg::SMP_W'($urandom));
				default: begin
					queue_cmd(2'($urandom_range(0, 2)), brs_pkg::SMP_W'($urandom));
					made++;
				end
			endcase
		end
	endtask

	// all items taken, all samples seen, then let the block settle
	task automatic wait_quiet();
		while (cmds_taken != cmds_queued || sample_forecast.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// command driver: new item or gap at the falling edge, holds until taken
	int send_gap = 0;
	cmd_item_t next_cmd;
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && !cmd_fire) begin
				// offer still pending, keep it stable
			end else if (send_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				send_gap--;
			end else if (cmd_backlog.size() != 0) begin
				if (idle_on && $urandom_range(0, 7) == 0) begin
					// gap burst with valid low
					cmd_ch.valid <= 1'b0;
					send_gap = $urandom_range(0, 15);
				end else begin
					next_cmd = cmd_backlog.pop_front();
					cmd_ch.valid   <= 1'b1;
					cmd_ch.command <= next_cmd.command;
					cmd_ch.target  <= next_cmd.target;
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result ready: random stall bursts and one long hold-off on request
	int recv_gap    = 0;
	int hold_left   = 0;
	int hold_served = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (recv_gap > 0) begin
				res_ch.ready <= 1'b0;
				recv_gap--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				recv_gap = $urandom_range(0, 15);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on command accept, check on result accept
	smp_item_t want;
	always @(posedge clk) begin
		cmd_fire = arst_n && cmd_ch.valid && cmd_ch.ready;
		if (cmd_fire) begin
			cmds_taken++;
			smooth_command(cmd_ch.command, cmd_ch.target);
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (sample_forecast.size() == 0) begin
				flag_mismatch("item with nothing expected", longint'(res_ch.sample_out), 0);
			end else begin
				want = sample_forecast.pop_front();
				if (res_ch.sample_out !== want.sample)
					flag_mismatch("sample_out", longint'(res_ch.sample_out),
						longint'(want.sample));
				if (res_ch.active !== want.active)
					flag_mismatch("active", longint'(res_ch.active), longint'(want.active));
				if (res_ch.last !== want.last)
					flag_mismatch("last", longint'(res_ch.last), longint'(want.last));
			end
		end
	end

	// run limit, well past the slowest legal run
	initial begin
		#12ms;
		$display("block_ramp_smoother_top verification failed");
		$finish;
	end

	// main sequence: reset, directed phases, random phases, final verdict
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = brs_pkg::REG_BLOCK_LEN;
		cfg_data       = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = brs_pkg::CMD_NEW;
		cmd_ch.target  = '0;
		res_ch.ready   = 1'b0;
		// predictor reset state
		m_len       = brs_pkg::LEN_W'(32);
		m_feed      = brs_pkg::COEF_ONE;
		m_fb        = '0;
		m_start     = '0;
		m_ramp      = '0;
		m_filt      = '0;
		m_cur       = '0;
		m_tgt       = '0;
		m_smoothing = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// reset settings: idle results, single samples, ignored command, full ramps
		queue_cmd(brs_pkg::CMD_NEW, '0);
		queue_cmd(brs_pkg::CMD_CONT, SMP_TOP);
		queue_cmd(brs_pkg::CMD_SINGLE, SMP_TOP);
		queue_cmd(brs_pkg::CMD_SINGLE, SMP_BOT);
		queue_cmd(CMD_IGNORED, SMP_TOP);
		queue_cmd(brs_pkg::CMD_NEW, SMP_TOP);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_NEW, SMP_BOT);
		queue_cmd(brs_pkg::CMD_CONT, SMP_BOT);
		wait_quiet();

		// zero block length, both gains above one, start at the top
		write_reg(brs_pkg::REG_BLOCK_LEN, '0);
		write_reg(brs_pkg::REG_FEED_COEF, brs_pkg::CFG_DATA_W'(131071));
		write_reg(brs_pkg::REG_FEEDBACK_COEF, brs_pkg::CFG_DATA_W'(131071));
		write_reg(brs_pkg::REG_START_VALUE, brs_pkg::CFG_DATA_W'(SMP_TOP));
		queue_cmd(brs_pkg::CMD_NEW, SMP_BOT);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_SINGLE, '0);
		queue_cmd(brs_pkg::CMD_NEW, SMP_TOP);
		wait_quiet();

		// oversize block length clips to the maximum, real lowpass
		write_reg(brs_pkg::REG_BLOCK_LEN, brs_pkg::CFG_DATA_W'(127));
		write_reg(brs_pkg::REG_FEED_COEF, brs_pkg::CFG_DATA_W'(16384));
		write_reg(brs_pkg::REG_FEEDBACK_COEF, brs_pkg::CFG_DATA_W'(49152));
		write_reg(brs_pkg::REG_START_VALUE, brs_pkg::CFG_DATA_W'(SMP_BOT));
		queue_cmd(brs_pkg::CMD_NEW, SMP_TOP);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		queue_cmd(brs_pkg::CMD_SINGLE, SMP_BOT);
		queue_cmd(brs_pkg::CMD_NEW, -24'sd1);
		wait_quiet();

		// one-sample blocks, zero feed with unity feedback freezes the filter
		write_reg(brs_pkg::REG_BLOCK_LEN, brs_pkg::CFG_DATA_W'(1));
		write_reg(brs_pkg::REG_FEED_COEF, '0);
		write_reg(brs_pkg::REG_FEEDBACK_COEF, brs_pkg::CFG_DATA_W'(65536));
		write_reg(brs_pkg::REG_START_VALUE, '0);
		queue_cmd(brs_pkg::CMD_NEW, SMP_TOP);
		queue_cmd(brs_pkg::CMD_CONT, '0);
		wait_quiet();

		// random phases, long result hold-off in the second, no idling in the last
		for (int p = 0; p < 6; p++) begin
			if (p == 5)
				idle_on = 1'b0;
			pick_settings();
			if (p == 1)
				hold_asked++;
			queue_random_phase(20);
			wait_quiet();
		end

		if (mismatch_cnt == 0)
			$display("block_ramp_smoother_top verification clean");
		else
			$display("block_ramp_smoother_top verification failed");
		$finish;
	end

endmodule
